FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// checked on every rising clock edge
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_CLK(lbl, clk, prop)

`endif

`endif

FILE: rtl/umf_pkg.sv
// ----------------------------------------------------------------------------
// umf_pkg
// types and constants of the ultrasonic median filter
// ----------------------------------------------------------------------------
package umf_pkg;

    localparam int DIST_W      = 13;
    localparam int ECHO_W      = 16;
    localparam int CMD_W       = 2;

    localparam logic [DIST_W-1:0] RESET_DIST = 13'd6400;

    // floor(x / 29) == (x * RECIP_MULT) >> RECIP_SHIFT for x below 2**19
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 20'd578525;
    localparam int SCALED_W    = ECHO_W + 3;
    localparam int PROD_W      = SCALED_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL  = 2'd0,
        CMD_ECHO  = 2'd1,
        CMD_RESET = 2'd2
    } cmd_t;

    typedef logic [DIST_W-1:0] dist_t;

endpackage

FILE: rtl/ultrasonic_median_filter.sv
// ----------------------------------------------------------------------------
// ultrasonic_median_filter
// ultrasonic range median filter with echo to distance scaling
// ----------------------------------------------------------------------------
// s_ channel takes a word per item: tuser carries the command (poll, echo,
// filter reset), tdata the echo pulse width in microseconds. m_ channel
// returns one word per item: tdata the current median distance in 1/16 cm,
// tuser a flag set when the item stored a nonzero echo reading.
// cfg_ channel writes max_range, the saturation and refill distance; write it
// only while no item is in flight.
// An accepted word sits in an input register; when it moves on, the scale,
// ring update and median select run in one pass into the result register,
// which drives m_tvalid. One word per cycle is sustained, since the input
// register moves on whenever the result register is empty or being taken
// in the same cycle.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; s_tready then drops until the result is taken.
// Reset clears both stages, sets max_range and every ring entry to 400 cm and
// rewinds the write position.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_median_filter import umf_pkg::*; #(
    parameter int WINDOW = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // echo_us [15:0]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // distance [12:0], zero [15:13]
    output logic [0:0]  m_tuser,   // took_reading [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data   // max_range [12:0]
);

    localparam int WP_W = $clog2(WINDOW);

    logic              in_vld_reg;
    cmd_t              in_cmd_reg;
    logic [ECHO_W-1:0] in_echo_reg;
    logic              out_vld_reg;
    logic              took_reg;
    logic              took_next;
    dist_t             max_range_reg;
    dist_t             ring_reg  [WINDOW];
    dist_t             ring_next [WINDOW];
    dist_t             ring_wr   [WINDOW];
    logic [WP_W-1:0]   write_pos_reg;
    logic [WP_W-1:0]   write_pos_next;
    logic [WP_W-1:0]   write_pos_inc;
    logic              await_first_reg;
    logic              await_first_next;
    dist_t             median_hold_reg;
    dist_t             median_hold_next;
    dist_t             range_dist;
    dist_t             median;
    logic              advance;
    logic              s_accept;

    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {{(16 - DIST_W){1'b0}}, median_hold_reg};
    assign m_tuser   = took_reg;

    umf_scale u_scale (
        .echo_us    (in_echo_reg),
        .max_range  (max_range_reg),
        .range_dist (range_dist)
    );

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            ring_wr[i] = (write_pos_reg == WP_W'(i)) ? range_dist : ring_reg[i];
        end
    end

    umf_median #(.WINDOW(WINDOW)) u_median (
        .vals   (ring_wr),
        .median (median)
    );

    assign write_pos_inc = (write_pos_reg == WP_W'(WINDOW - 1)) ? '0
                                                               : write_pos_reg + WP_W'(1);

    always_comb begin
        ring_next        = ring_reg;
        write_pos_next   = write_pos_reg;
        await_first_next = await_first_reg;
        median_hold_next = median_hold_reg;
        took_next        = 1'b0;
        case (in_cmd_reg)
            CMD_RESET: begin
                for (int i = 0; i < WINDOW; i++) begin
                    ring_next[i] = max_range_reg;
                end
                write_pos_next   = '0;
                median_hold_next = max_range_reg;
                await_first_next = 1'b1;
            end
            CMD_ECHO: begin
                if (in_echo_reg != '0) begin
                    took_next = 1'b1;
                    if (await_first_reg) begin
                        for (int i = 0; i < WINDOW; i++) begin
                            ring_next[i] = range_dist;
                        end
                        median_hold_next = range_dist;
                        write_pos_next   = WP_W'(1);
                        await_first_next = 1'b0;
                    end else begin
                        ring_next        = ring_wr;
                        write_pos_next   = write_pos_inc;
                        median_hold_next = median;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            max_range_reg   <= RESET_DIST;
            write_pos_reg   <= '0;
            await_first_reg <= 1'b0;
            median_hold_reg <= RESET_DIST;
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= RESET_DIST;
            end
        end else begin
            if (s_accept) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg     <= 1'b1;
                ring_reg        <= ring_next;
                write_pos_reg   <= write_pos_next;
                await_first_reg <= await_first_next;
                median_hold_reg <= median_hold_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid) begin
                max_range_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg  <= cmd_t'(s_tuser);
            in_echo_reg <= s_tdata;
        end
        if (advance) begin
            took_reg <= took_next;
        end
    end

    `ASSERT_RST(a_wp_in_range, aclk, aresetn, write_pos_reg <= WP_W'(WINDOW - 1))
    `ASSERT_RST(a_state_holds, aclk, aresetn,
                !advance |=> $stable(write_pos_reg) && $stable(median_hold_reg))
    `ASSERT_RST(a_reset_cmd, aclk, aresetn,
                advance && in_cmd_reg == CMD_RESET
                |=> !took_reg && await_first_reg && write_pos_reg == '0)
    `ASSERT_RST(a_empty_ready, aclk, aresetn, !in_vld_reg |-> s_tready)

endmodule

FILE: rtl/umf_scale.sv
// ----------------------------------------------------------------------------
// umf_scale
// echo width in us to distance in 1/16 cm, saturated at max range
// ----------------------------------------------------------------------------
module umf_scale import umf_pkg::*; (
    input  logic [ECHO_W-1:0] echo_us,
    input  dist_t             max_range,
    output dist_t             range_dist
);

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;

    // echo * 8 / 29 by reciprocal multiply
    assign prod = PROD_W'({echo_us, 3'b000}) * PROD_W'(RECIP_MULT);
    assign quot = prod[RECIP_SHIFT +: QUOT_W];
    assign range_dist = (quot > QUOT_W'(max_range)) ? max_range : quot[DIST_W-1:0];

endmodule

FILE: rtl/umf_median.sv
// ----------------------------------------------------------------------------
// umf_median
// rank based median select over the window entries
// ----------------------------------------------------------------------------
module umf_median import umf_pkg::*; #(
    parameter int WINDOW = 5
) (
    input  dist_t vals [WINDOW],
    output dist_t median
);

    localparam int MID = WINDOW / 2;

    logic [WINDOW-1:0] below [WINDOW];
    logic [WINDOW-1:0] hit;

    // ties broken by entry order so that ranks form a permutation
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW; j++) begin
                below[i][j] = (vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i));
            end
        end
    end

    always_comb begin
        median = '0;
        for (int i = 0; i < WINDOW; i++) begin
            hit[i] = ($countones(below[i]) == MID);
            median = median | (vals[i] & {DIST_W{hit[i]}});
        end
    end

endmodule

FILE: tb/ultrasonic_median_filter_tb.sv
// ----------------------------------------------------------------------------
// ultrasonic_median_filter_tb
// Self-checking bench for the ultrasonic median filter. Polls, echo readings
// and filter resets go in on the s_ stream, while max_range is changed
// between phases. A behavioral copy of the filter predicts each m_ word, and
// every result is checked field by field. Both sides throttle at random.
// ----------------------------------------------------------------------------
module ultrasonic_median_filter_tb import umf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILTER_LEN = 5;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        dist_t distance;
        logic  took;
    } reading_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // echo_us [15:0]
    logic [1:0]  s_tuser;   // cmd [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // distance [12:0], zero [15:13]
    logic [0:0]  m_tuser;   // took_reading [0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;  // max_range [12:0]

    // filter state mirror
    dist_t ring_q [FILTER_LEN];
    int    wr_pos;
    logic  await_first;
    dist_t median_q;
    dist_t max_range_q;

    reading_t pending_readings[$];

    bit no_idle;
    int n_fail;
    int n_items;
    int n_results;
    int n_readings;
    int n_resets;
    int n_cfg;

    ultrasonic_median_filter #(
        .WINDOW(FILTER_LEN)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("ultrasonic_median_filter test failed");
        $finish;
    end

    function automatic dist_t median_of_ring();
        dist_t s [FILTER_LEN];
        dist_t t;
        foreach (ring_q[i]) s[i] = ring_q[i];
        for (int i = 0; i < FILTER_LEN - 1; i++) begin
            for (int j = 0; j < FILTER_LEN - 1 - i; j++) begin
                if (s[j] > s[j+1]) begin
                    t      = s[j];
                    s[j]   = s[j+1];
                    s[j+1] = t;
                end
            end
        end
        return s[FILTER_LEN/2];
    endfunction

    function automatic reading_t advance_range_filter(logic [CMD_W-1:0] cmd,
                                                      logic [ECHO_W-1:0] echo);
        reading_t    r;
        int unsigned d;
        r.took = 1'b0;
        if (cmd == CMD_RESET) begin
            foreach (ring_q[i]) ring_q[i] = max_range_q;
            wr_pos      = 0;
            median_q    = max_range_q;
            await_first = 1'b1;
        end else if (cmd == CMD_ECHO && echo != '0) begin
            d = (32'(echo) * 8) / 29;
            if (d > 32'(max_range_q)) d = 32'(max_range_q);
            r.took = 1'b1;
            if (await_first) begin
                foreach (ring_q[i]) ring_q[i] = dist_t'(d);
                median_q    = dist_t'(d);
                wr_pos      = 1 % FILTER_LEN;
                await_first = 1'b0;
            end else begin
                ring_q[wr_pos] = dist_t'(d);
                wr_pos         = (wr_pos + 1) % FILTER_LEN;
                median_q       = median_of_ring();
            end
        end
        r.distance = median_q;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin : check_results
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual distance %0d took %0b",
                         $time, m_tdata[DIST_W-1:0], m_tuser[0]);
                n_fail++;
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata[DIST_W-1:0] !== want.distance) begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, want.distance, m_tdata[DIST_W-1:0]);
                    n_fail++;
                end
                if (m_tuser[0] !== want.took) begin
                    $display("%0t: took_reading mismatch, expected %0b, actual %0b",
                             $time, want.took, m_tuser[0]);
                    n_fail++;
                end
            end
        end
    end

    // receiver throttling
    initial begin : drive_ready
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ECHO_W-1:0] echo);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = echo;
        do @(posedge aclk); while (!s_tready);
        pending_readings.push_back(advance_range_filter(cmd, echo));
        n_items++;
        if (cmd == CMD_RESET) n_resets++;
        if (cmd == CMD_ECHO && echo != '0) n_readings++;
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (pending_readings.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_max_range(input logic [12:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        max_range_q = value;
        n_cfg++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [ECHO_W-1:0] pick_echo();
        int unsigned edge_echo;
        edge_echo = (32'(max_range_q) * 29) / 8;
        case ($urandom_range(0, 9))
            0: return ECHO_W'($urandom_range(1, 63));
            1, 2: return ECHO_W'($urandom);
            3: begin
                edge_echo = edge_echo + $urandom_range(0, 16);
                edge_echo = (edge_echo > 8) ? edge_echo - 8 : 1;
                return (edge_echo > 65535) ? 16'hFFFF : ECHO_W'(edge_echo);
            end
            4: return 16'hFFFF - ECHO_W'($urandom_range(0, 3));
            default: begin
                edge_echo = edge_echo + 200;
                if (edge_echo > 65535) edge_echo = 65535;
                return ECHO_W'($urandom_range(1, edge_echo));
            end
        endcase
    endfunction

    task automatic send_random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            send_word(CMD_RESET, ECHO_W'($urandom));
        else if (pick < 14)
            send_word(CMD_POLL, ECHO_W'($urandom));
        else if (pick < 18)
            send_word(CMD_ECHO, '0);
        else if (pick < 20)
            send_word(CMD_UNUSED, ECHO_W'($urandom));
        else
            send_word(CMD_ECHO, pick_echo());
    endtask

    task automatic test_directed_edges();
        send_word(CMD_POLL, 16'h0000);
        send_word(CMD_UNUSED, 16'hFFFF);
        send_word(CMD_ECHO, 16'h0000);
        send_word(CMD_ECHO, 16'd1);
        send_word(CMD_ECHO, 16'hFFFF);
        send_word(CMD_ECHO, 16'd23200);
        send_word(CMD_ECHO, 16'd23204);
        send_word(CMD_ECHO, 16'd28);
        send_word(CMD_ECHO, 16'd29);
        send_word(CMD_RESET, 16'hFFFF);
        send_word(CMD_ECHO, 16'd1000);
        send_word(CMD_ECHO, 16'd29);
        send_word(CMD_ECHO, 16'd58);
        send_word(CMD_POLL, 16'hFFFF);
        send_word(CMD_ECHO, 16'h8000);
        send_word(CMD_ECHO, 16'h5555);
        send_word(CMD_ECHO, 16'hAAAA);
        send_word(CMD_RESET, 16'h0000);
        send_word(CMD_ECHO, 16'h0000);
        send_word(CMD_ECHO, 16'hFFFF);
        wait_drain();
    endtask

    task automatic test_range_extremes();
        write_max_range(13'd0);
        send_word(CMD_ECHO, 16'hFFFF);
        send_word(CMD_RESET, 16'h1234);
        send_word(CMD_ECHO, 16'd100);
        wait_drain();
        write_max_range(13'h1FFF);
        send_word(CMD_ECHO, 16'hFFFF);
        send_word(CMD_ECHO, 16'd29700);
        send_word(CMD_RESET, 16'h0000);
        send_word(CMD_POLL, 16'h0000);
        send_word(CMD_ECHO, 16'hFFFF);
        wait_drain();
        write_max_range(13'd1);
        send_word(CMD_ECHO, 16'd3);
        send_word(CMD_ECHO, 16'd4);
        send_word(CMD_ECHO, 16'hFFFF);
        send_word(CMD_RESET, 16'h0000);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        logic [12:0] settings [8];
        settings = '{13'd6400, 13'd0, 13'h1FFF, 13'd1, 13'd4000, 13'd100, 13'd0, 13'h1FFF};
        foreach (settings[p]) begin
            write_max_range((p >= 6) ? 13'($urandom) : settings[p]);
            if ($urandom_range(0, 1)) send_word(CMD_RESET, ECHO_W'($urandom));
            for (int i = 0; i < 210; i++) begin
                if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) == 0) wait_drain();
                send_random_word();
            end
            no_idle = 1'b0;
            wait_drain();
        end
    endtask

    task automatic test_back_to_back();
        write_max_range(RESET_DIST);
        no_idle = 1'b1;
        for (int i = 0; i < 160; i++) send_random_word();
        no_idle = 1'b0;
        wait_drain();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_POLL;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        foreach (ring_q[i]) ring_q[i] = RESET_DIST;
        wr_pos      = 0;
        await_first = 1'b0;
        median_q    = RESET_DIST;
        max_range_q = RESET_DIST;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed_edges();
        test_range_extremes();
        test_random_traffic();
        test_back_to_back();

        wait_drain();
        repeat (5) @(negedge aclk);
        $display("covered %0d words in, %0d words out, %0d stored readings, %0d filter resets",
                 n_items, n_results, n_readings, n_resets);
        $display("max_range rewritten %0d times, including 0 and 8191, under random throttling",
                 n_cfg);
        if (n_fail == 0 && pending_readings.size() == 0) begin
            $display("ultrasonic_median_filter test passed");
        end else begin
            $display("ultrasonic_median_filter test failed");
        end
        $finish;
    end

endmodule
